FILE: rtl/rit_pkg.sv
// rit_pkg: shared types, constants and helpers for the rollback input timeline
// depends on nothing; used by rit_ring and rollback_input_timeline
`timescale 1ns / 1ps
`default_nettype none

package rit_pkg;

    localparam int WINDOW_FRAMES       = 64;
    localparam int SLOT_W              = $clog2(WINDOW_FRAMES);
    localparam int MAX_DELAY_FRAMES    = 8;
    localparam int MAX_ROLLBACK_FRAMES = 16;
    localparam int PLAYER_SLOTS        = 8;
    localparam int AHEAD_SLACK         = 8;
    localparam int PRUNE_SLACK         = 2;
    localparam int AHEAD_SPAN          = MAX_DELAY_FRAMES + MAX_ROLLBACK_FRAMES + AHEAD_SLACK;

    localparam logic [2:0] CFG_LOCAL  = 3'd0;
    localparam logic [2:0] CFG_REMOTE = 3'd1;
    localparam logic [2:0] CFG_DELAY  = 3'd2;
    localparam logic [2:0] CFG_WINDOW = 3'd3;
    localparam logic [2:0] CFG_FIRST  = 3'd4;

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_SUBMIT   = 3'd1,
        OP_PREPARE  = 3'd2,
        OP_REPLAY   = 3'd3,
        OP_TAKE     = 3'd4,
        OP_DISCARD  = 3'd5,
        OP_PRUNE    = 3'd6,
        OP_STOP     = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_CFG   = 3'd1,
        ST_BAD_CFG   = 3'd2,
        ST_TOO_OLD   = 3'd3,
        ST_TOO_FAR   = 3'd4,
        ST_CONFLICT  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SUB,
        S_PREP,
        S_USE_RD,
        S_USE_HIT,
        S_SCAN,
        S_USE_WR
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [63:0] frame_index;
        logic [63:0] emulation_frame;
        logic [31:0] input_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] snapshot_sequence;
        logic [31:0] local_value;
        logic [31:0] remote_value;
        logic        remote_was_predicted;
        logic [63:0] outgoing_frame;
        logic [31:0] outgoing_value;
        logic        rollback_valid;
        logic [63:0] rollback_target;
        logic [31:0] predicted_total;
        logic [31:0] rollback_total;
        logic [31:0] rejected_total;
    } t_out_item;

    typedef struct packed {
        logic [63:0] tag;
        logic [31:0] value;
    } t_ring_entry;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rollback_input_timeline.sv
// rollback input timeline: local, remote and used input rings with prediction
// strobe after accept: start, stop, take and window rejects end in the execute state;
// submits read the remote ring; replay and prepare read the rings and, if the remote
// input is predicted, search all 64 remote ring entries, one read a cycle; discard and
// prune scan all entries. one item at a time, busy until the strobe; no result stall
// reset clears all valid bits at once, so no clearing pass follows it
`timescale 1ns / 1ps
`default_nettype none

module rollback_input_timeline (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rit_pkg::t_in_item  i_in,
    output logic                    o_done,
    output rit_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);
    import rit_pkg::*;

    t_state r_state, n_state;
    t_op    r_op;
    logic [63:0] r_frame, r_cur, r_target, n_target, r_bound, n_bound;
    logic [31:0] r_word;
    logic [31:0] r_lv, n_lv, r_rv, n_rv;
    logic        r_pred, n_pred, r_have, n_have;
    logic [63:0] r_best, n_best;
    logic [SLOT_W:0]   r_idx, n_idx;
    logic              r_chk, n_chk;
    logic [SLOT_W-1:0] r_pidx, n_pidx;

    logic        r_active, n_active;
    logic [3:0]  r_sdelay, n_sdelay;
    logic [4:0]  r_swindow, n_swindow;
    logic [63:0] r_sfirst, n_sfirst;

    logic [2:0]  r_cfg_local, r_cfg_remote;
    logic [3:0]  r_cfg_delay;
    logic [4:0]  r_cfg_window;
    logic [63:0] r_cfg_first;

    logic [WINDOW_FRAMES-1:0] r_lvalid, n_lvalid, r_rvalid, n_rvalid, r_uvalid, n_uvalid;
    logic        r_pend, n_pend;
    logic [63:0] r_pend_frame, n_pend_frame;
    logic [31:0] r_cnt_pred, n_cnt_pred, r_cnt_rb, n_cnt_rb, r_cnt_rej, n_cnt_rej;
    logic        r_strobe, n_strobe;
    t_out_item   r_res, n_res;

    logic              l_we, rm_we, u_we;
    logic [SLOT_W-1:0] l_waddr, rm_waddr, u_waddr, l_raddr, rm_raddr, u_raddr;
    t_ring_entry       l_wdata, rm_wdata, u_wdata, l_rd, rm_rd, u_rd;

    rit_ring u_local (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rd)
    );
    rit_ring u_remote (
        .i_clk(i_clk), .i_we(rm_we), .i_waddr(rm_waddr), .i_wdata(rm_wdata),
        .i_raddr(rm_raddr), .o_rdata(rm_rd)
    );
    rit_ring u_used (
        .i_clk(i_clk), .i_we(u_we), .i_waddr(u_waddr), .i_wdata(u_wdata),
        .i_raddr(u_raddr), .o_rdata(u_rd)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_strobe;

    always_comb begin
        o_out                 = r_res;
        o_out.predicted_total = r_cnt_pred;
        o_out.rollback_total  = r_cnt_rb;
        o_out.rejected_total  = r_cnt_rej;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_local  <= 3'd0;
            r_cfg_remote <= 3'd1;
            r_cfg_delay  <= 4'd0;
            r_cfg_window <= 5'd1;
            r_cfg_first  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LOCAL:  r_cfg_local  <= i_cfg_data[2:0];
                CFG_REMOTE: r_cfg_remote <= i_cfg_data[2:0];
                CFG_DELAY:  r_cfg_delay  <= i_cfg_data[3:0];
                CFG_WINDOW: r_cfg_window <= i_cfg_data[4:0];
                CFG_FIRST:  r_cfg_first  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item fields, latched at accept
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op    <= i_in.operation;
            r_frame <= i_in.frame_index;
            r_cur   <= i_in.emulation_frame;
            r_word  <= i_in.input_word;
        end
        r_target <= n_target;
        r_bound  <= n_bound;
        r_lv     <= n_lv;
        r_rv     <= n_rv;
        r_pred   <= n_pred;
        r_have   <= n_have;
        r_best   <= n_best;
        r_pidx   <= n_pidx;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_chk        <= 1'b0;
            r_active     <= 1'b0;
            r_sdelay     <= '0;
            r_swindow    <= 5'd1;
            r_sfirst     <= '0;
            r_lvalid     <= '0;
            r_rvalid     <= '0;
            r_uvalid     <= '0;
            r_pend       <= 1'b0;
            r_pend_frame <= '0;
            r_cnt_pred   <= '0;
            r_cnt_rb     <= '0;
            r_cnt_rej    <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_chk        <= n_chk;
            r_active     <= n_active;
            r_sdelay     <= n_sdelay;
            r_swindow    <= n_swindow;
            r_sfirst     <= n_sfirst;
            r_lvalid     <= n_lvalid;
            r_rvalid     <= n_rvalid;
            r_uvalid     <= n_uvalid;
            r_pend       <= n_pend;
            r_pend_frame <= n_pend_frame;
            r_cnt_pred   <= n_cnt_pred;
            r_cnt_rb     <= n_cnt_rb;
            r_cnt_rej    <= n_cnt_rej;
            r_strobe     <= n_strobe;
        end
    end

    always_comb begin
        logic [63:0]       ws, oldest, ahead, pws, poldest;
        logic [6:0]        pspan;
        logic [SLOT_W-1:0] fslot, tslot;
        logic              cfg_ok;

        fslot   = r_frame[SLOT_W-1:0];
        tslot   = r_target[SLOT_W-1:0];
        ws      = (r_cur > {59'd0, r_swindow}) ? r_cur - {59'd0, r_swindow} : '0;
        oldest  = (ws > r_sfirst) ? ws : r_sfirst;
        ahead   = sat_add(r_cur, 64'(AHEAD_SPAN));
        pspan   = {2'd0, r_swindow} + {3'd0, r_sdelay} + 7'(PRUNE_SLACK);
        pws     = (r_cur > {57'd0, pspan}) ? r_cur - {57'd0, pspan} : '0;
        poldest = (pws > r_sfirst) ? pws : r_sfirst;
        cfg_ok  = (32'(r_cfg_local) < PLAYER_SLOTS) && (32'(r_cfg_remote) < PLAYER_SLOTS)
                  && (r_cfg_local != r_cfg_remote)
                  && (32'(r_cfg_delay) <= MAX_DELAY_FRAMES)
                  && (r_cfg_window != 5'd0)
                  && (32'(r_cfg_window) <= MAX_ROLLBACK_FRAMES);

        n_state      = r_state;
        n_target     = r_target;
        n_bound      = r_bound;
        n_lv         = r_lv;
        n_rv         = r_rv;
        n_pred       = r_pred;
        n_have       = r_have;
        n_best       = r_best;
        n_idx        = r_idx;
        n_chk        = 1'b0;
        n_pidx       = r_pidx;
        n_active     = r_active;
        n_sdelay     = r_sdelay;
        n_swindow    = r_swindow;
        n_sfirst     = r_sfirst;
        n_lvalid     = r_lvalid;
        n_rvalid     = r_rvalid;
        n_uvalid     = r_uvalid;
        n_pend       = r_pend;
        n_pend_frame = r_pend_frame;
        n_cnt_pred   = r_cnt_pred;
        n_cnt_rb     = r_cnt_rb;
        n_cnt_rej    = r_cnt_rej;
        n_strobe     = 1'b0;
        n_res        = r_res;

        l_we = 1'b0; l_waddr = fslot; l_wdata = '{tag: r_target, value: r_word};
        rm_we = 1'b0; rm_waddr = fslot; rm_wdata = '{tag: r_frame, value: r_word};
        u_we = 1'b0; u_waddr = fslot; u_wdata = '{tag: r_frame, value: r_rv};
        l_raddr  = fslot;
        rm_raddr = fslot;
        u_raddr  = fslot;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res = '0;
                if (r_op == OP_START) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (!cfg_ok) begin
                        n_res.status = ST_BAD_CFG;
                    end else begin
                        n_lvalid     = '0;
                        n_rvalid     = '0;
                        n_uvalid     = '0;
                        n_pend       = 1'b0;
                        n_pend_frame = '0;
                        n_cnt_pred   = '0;
                        n_cnt_rb     = '0;
                        n_cnt_rej    = '0;
                        n_active     = 1'b1;
                        n_sdelay     = r_cfg_delay;
                        n_swindow    = r_cfg_window;
                        n_sfirst     = r_cfg_first;
                    end
                end else if (r_op == OP_STOP) begin
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                    n_lvalid     = '0;
                    n_rvalid     = '0;
                    n_uvalid     = '0;
                    n_pend       = 1'b0;
                    n_pend_frame = '0;
                    n_cnt_pred   = '0;
                    n_cnt_rb     = '0;
                    n_cnt_rej    = '0;
                    n_active     = 1'b0;
                end else if (!r_active) begin
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                    n_res.status = ST_NOT_CFG;
                end else begin
                    unique case (r_op)
                        OP_SUBMIT: begin
                            if (r_frame < oldest) begin
                                n_cnt_rej    = sat_inc(r_cnt_rej);
                                n_res.status = ST_TOO_OLD;
                                n_strobe     = 1'b1;
                                n_state      = S_IDLE;
                            end else if (r_frame > ahead) begin
                                n_cnt_rej    = sat_inc(r_cnt_rej);
                                n_res.status = ST_TOO_FAR;
                                n_strobe     = 1'b1;
                                n_state      = S_IDLE;
                            end else begin
                                n_state = S_SUB;
                            end
                        end
                        OP_PREPARE: begin
                            n_target = sat_add(r_frame, {60'd0, r_sdelay});
                            l_raddr  = n_target[SLOT_W-1:0];
                            n_state  = S_PREP;
                        end
                        OP_REPLAY: begin
                            n_state = S_USE_RD;
                        end
                        OP_TAKE: begin
                            n_res.rollback_valid  = r_pend;
                            n_res.rollback_target = r_pend ? r_pend_frame : '0;
                            n_pend       = 1'b0;
                            n_pend_frame = '0;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end
                        OP_PRUNE, OP_DISCARD: begin
                            n_bound = poldest;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SUB: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                if (r_rvalid[fslot] && rm_rd.tag == r_frame) begin
                    if (rm_rd.value != r_word) begin
                        n_cnt_rej    = sat_inc(r_cnt_rej);
                        n_res.status = ST_CONFLICT;
                    end
                end else begin
                    rm_we           = 1'b1;
                    n_rvalid[fslot] = 1'b1;
                    if (r_uvalid[fslot] && u_rd.tag == r_frame && u_rd.value != r_word) begin
                        if (!r_pend || r_frame < r_pend_frame) begin
                            n_pend_frame = r_frame;
                        end
                        n_pend   = 1'b1;
                        n_cnt_rb = sat_inc(r_cnt_rb);
                    end
                end
            end

            S_PREP: begin
                if (!(r_lvalid[tslot] && l_rd.tag == r_target)) begin
                    l_we            = 1'b1;
                    l_waddr         = tslot;
                    n_lvalid[tslot] = 1'b1;
                end
                n_state = S_USE_RD;
            end

            S_USE_RD: begin
                n_state = S_USE_HIT;
            end

            S_USE_HIT: begin
                n_lv = (r_lvalid[fslot] && l_rd.tag == r_frame) ? l_rd.value : '0;
                if (r_rvalid[fslot] && rm_rd.tag == r_frame) begin
                    n_rv    = rm_rd.value;
                    n_pred  = 1'b0;
                    n_state = S_USE_WR;
                end else begin
                    n_rv    = '0;
                    n_pred  = 1'b1;
                    n_have  = 1'b0;
                    n_best  = '0;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // one entry read per cycle, checked in the next cycle
                l_raddr  = r_idx[SLOT_W-1:0];
                rm_raddr = r_idx[SLOT_W-1:0];
                u_raddr  = r_idx[SLOT_W-1:0];
                n_pidx   = r_idx[SLOT_W-1:0];
                n_chk    = !r_idx[SLOT_W];
                n_idx    = r_idx[SLOT_W] ? r_idx : r_idx + 1'b1;
                if (r_chk) begin
                    priority case (r_op)
                        OP_DISCARD: begin
                            if (r_uvalid[r_pidx] && u_rd.tag >= r_frame) begin
                                n_uvalid[r_pidx] = 1'b0;
                            end
                        end
                        OP_PRUNE: begin
                            if (r_lvalid[r_pidx] && l_rd.tag < r_bound) begin
                                n_lvalid[r_pidx] = 1'b0;
                            end
                            if (r_rvalid[r_pidx] && rm_rd.tag < r_bound) begin
                                n_rvalid[r_pidx] = 1'b0;
                            end
                            if (r_uvalid[r_pidx] && u_rd.tag < r_bound) begin
                                n_uvalid[r_pidx] = 1'b0;
                            end
                        end
                        default: begin
                            // latest stored remote input before the frame
                            if (r_rvalid[r_pidx] && rm_rd.tag < r_frame
                                    && (!r_have || rm_rd.tag > r_best)) begin
                                n_have = 1'b1;
                                n_best = rm_rd.tag;
                                n_rv   = rm_rd.value;
                            end
                        end
                    endcase
                end
                if (r_idx[SLOT_W] && !r_chk) begin
                    if (r_op == OP_DISCARD || r_op == OP_PRUNE) begin
                        n_res    = '0;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_USE_WR;
                    end
                end
            end

            S_USE_WR: begin
                u_we            = 1'b1;
                n_uvalid[fslot] = 1'b1;
                n_res                      = '0;
                n_res.snapshot_sequence    = sat_add(r_frame, 64'd1);
                n_res.local_value          = r_lv;
                n_res.remote_value         = r_rv;
                n_res.remote_was_predicted = r_pred;
                if (r_op == OP_PREPARE) begin
                    n_res.outgoing_frame = r_target;
                    n_res.outgoing_value = r_word;
                    if (r_pred) begin
                        n_cnt_pred = sat_inc(r_cnt_pred);
                    end
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a result only follows work on an item
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state) != S_IDLE)
        else $error("result strobe without an item in progress");

    // every item passes through the execute state after accept, so strobes never touch
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobes in consecutive cycles");

    // a rollback request only exists inside an active session
    a_pend_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> !r_pend)
        else $error("rollback pending while session inactive");

    // a scan always starts from the first entry
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && $past(r_state) != S_SCAN) |-> (r_idx == '0 && !r_chk))
        else $error("ring scan entered mid-way");

endmodule

`default_nettype wire

FILE: rtl/rit_ring.sv
// rit_ring: one ring of tagged entries, one write and one registered read per cycle
// depends on rit_pkg
`timescale 1ns / 1ps
`default_nettype none

module rit_ring (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [rit_pkg::SLOT_W-1:0]  i_waddr,
    input  wire rit_pkg::t_ring_entry        i_wdata,
    input  wire logic [rit_pkg::SLOT_W-1:0]  i_raddr,
    output rit_pkg::t_ring_entry             o_rdata
);
    import rit_pkg::*;

    t_ring_entry r_mem [WINDOW_FRAMES];
    t_ring_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
